// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the digit converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on the rising edge of clk, ignored while rst is high.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that b holds in the same cycle as a.
`define ASSERT_IMPLIES(label, clk, rst, a, b, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_IMPLIES(label, clk, rst, a, b, msg)
`endif
`endif

// ===== rtl/core/itoa_pkg.sv =====
// Types, constants and helper functions of the integer to ASCII digit converter.
`default_nettype none
package itoa_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int DIGIT_WIDTH = 4;
   localparam int DEC_DIGITS  = 20;
   localparam int HEX_DIGITS  = (VALUE_WIDTH + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
   localparam int BCD_WIDTH   = DEC_DIGITS * DIGIT_WIDTH;
   localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
   localparam int IDX_W       = $clog2(DEC_DIGITS);
   localparam int SEL_W       = $clog2(BCD_WIDTH);
   localparam int CHAR_W      = 7;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
   localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'h41;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_NINE = 4'd9;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_TEN = 4'd10;

   // Radix select codes
   localparam logic OP_DECIMAL = 1'b0;
   localparam logic OP_HEX     = 1'b1;

   // Commands from the sequencer to the conversion unit
   typedef struct packed {
      logic load;
      logic shift;
      logic hex;
   } cvt_ctrl_type;

   // Map one digit (0..15) to its ASCII code, upper-case letters above nine
   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_WIDTH-1:0] d);
      logic [CHAR_W-1:0] code;
      if (d > DIGIT_NINE) begin
         code = ASCII_UPPER_A + CHAR_W'(d - DIGIT_TEN);
      end else begin
         code = ASCII_ZERO + CHAR_W'(d);
      end
      return code;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/integer_to_ascii_digits.sv =====
// Top level: sequencer and character emitter of the integer to ASCII converter.
//
//   channel   ports                                  handshake
//   request   req_value, req_operation               start high while busy low
//   response  rsp_character, rsp_last                rsp_strobe, one cycle each
//
// Decimal: a load step, then conversion steps that each shift one bit of the value
// through the add-3 unit, then a scan of the 20 digits, leading zeros skipped.
// Hex: a load step and a scan of the 16 hex digits.
// Each character leaves from output registers in the cycle after its scan step.
// Synchronous reset returns the sequencer to idle and drops the strobe.
// The receiver cannot stall; busy holds off new transactions while one is in work.
`default_nettype none
`include "assert_macros.svh"
module integer_to_ascii_digits (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [itoa_pkg::VALUE_WIDTH-1:0] req_value,
   input  wire logic                             req_operation,
   output logic                                  rsp_strobe,
   output logic [itoa_pkg::CHAR_W-1:0]           rsp_character,
   output logic                                  rsp_last
);
   import itoa_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [BIT_CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 started_ff, started_in;
   logic                 strobe_ff, strobe_in;
   logic [CHAR_W-1:0]    char_ff, char_in;
   logic                 last_ff, last_in;

   cvt_ctrl_type         ctrl;
   logic [BCD_WIDTH-1:0] digits;
   logic [DIGIT_WIDTH-1:0] cur_digit;
   logic                 emit_now;

   itoa_cvt u_cvt (
      .clock  (clock),
      .ctrl   (ctrl),
      .value  (req_value),
      .digits (digits)
   );

   // Select the digit under the scan pointer
   assign cur_digit = digits[{idx_ff, 2'b00} +: DIGIT_WIDTH];
   assign emit_now  = (cur_digit != '0) || started_ff || (idx_ff == '0);

   // Sequence load, conversion and digit scan
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      started_in = started_ff;
      strobe_in  = 1'b0;
      char_in    = char_ff;
      last_in    = 1'b0;
      ctrl.load  = 1'b0;
      ctrl.shift = 1'b0;
      ctrl.hex   = (req_operation == OP_HEX);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctrl.load  = 1'b1;
               started_in = 1'b0;
               count_in   = '0;
               if (req_operation == OP_HEX) begin
                  idx_in   = IDX_W'(HEX_DIGITS - 1);
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            ctrl.shift = 1'b1;
            count_in   = count_ff + 1'b1;
            if (count_ff == BIT_CNT_W'(VALUE_WIDTH - 1)) begin
               idx_in   = IDX_W'(DEC_DIGITS - 1);
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_now) begin
               strobe_in  = 1'b1;
               char_in    = digit_to_ascii(cur_digit);
               last_in    = (idx_ff == '0);
               started_in = 1'b1;
            end
            if (idx_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         strobe_ff  <= 1'b0;
         last_ff    <= 1'b0;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         strobe_ff  <= strobe_in;
         last_ff    <= last_in;
         started_ff <= started_in;
      end
   end

   // Payload registers hold without reset
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      idx_ff   <= idx_in;
      char_ff  <= char_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = strobe_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

   `ASSERT_PROP(a_strobe_from_emit, clock, reset, rsp_strobe |-> $past(state_ff == ST_EMIT), "strobe without scan step")
   `ASSERT_IMPLIES(a_last_has_strobe, clock, reset, rsp_last, rsp_strobe, "last flag without strobe")
   `ASSERT_PROP(a_start_sets_busy, clock, reset, (start && !busy) |=> busy, "accepted transaction did not raise busy")
   `ASSERT_PROP(a_final_digit_sent, clock, reset, (state_ff == ST_EMIT && idx_ff == '0) |=> (rsp_strobe && rsp_last), "final digit not sent with last")

endmodule
`default_nettype wire

// ===== rtl/core/itoa_cvt.sv =====
// Shift-and-add-3 binary to BCD unit; loads hex nibbles directly.
`default_nettype none
module itoa_cvt (
   input  wire logic                           clock,
   input  wire itoa_pkg::cvt_ctrl_type         ctrl,
   input  wire logic [itoa_pkg::VALUE_WIDTH-1:0] value,
   output logic [itoa_pkg::BCD_WIDTH-1:0]      digits
);
   import itoa_pkg::*;

   logic [VALUE_WIDTH-1:0] bin_ff;
   logic [VALUE_WIDTH-1:0] bin_in;
   logic [BCD_WIDTH-1:0]   bcd_ff;
   logic [BCD_WIDTH-1:0]   bcd_in;
   logic [BCD_WIDTH-1:0]   bcd_adj;

   // Add three to every BCD digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_WIDTH +: DIGIT_WIDTH] >= DIGIT_WIDTH'(5)) begin
            bcd_adj[i*DIGIT_WIDTH +: DIGIT_WIDTH] =
               bcd_ff[i*DIGIT_WIDTH +: DIGIT_WIDTH] + DIGIT_WIDTH'(3);
         end else begin
            bcd_adj[i*DIGIT_WIDTH +: DIGIT_WIDTH] = bcd_ff[i*DIGIT_WIDTH +: DIGIT_WIDTH];
         end
      end
   end

   // Load the operand, or shift one binary bit into the BCD word
   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (ctrl.load) begin
         bin_in = value;
         if (ctrl.hex) begin
            bcd_in = {{(BCD_WIDTH-VALUE_WIDTH){1'b0}}, value};
         end else begin
            bcd_in = '0;
         end
      end else if (ctrl.shift) begin
         bin_in = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
         bcd_in = {bcd_adj[BCD_WIDTH-2:0], bin_ff[VALUE_WIDTH-1]};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign digits = bcd_ff;

endmodule
`default_nettype wire
